@@ rtl/ggpc_pkg.sv @@
package ggpc_pkg;

  // Internal field widths, sized for the largest grid the block supports.
  localparam int CW     = 10;  // coordinate
  localparam int AW_MAX = 20;  // pixel address
  localparam int KW     = 6;   // cluster index
  localparam int TW     = 7;   // cluster total
  localparam int DW     = 21;  // squared distance
  localparam int PW     = 20;  // pixel count
  localparam int SW     = 24;  // cluster count
  localparam int DIMW   = 11;  // grid dimension

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [6:0]  pixel_x;
    logic [6:0]  pixel_y;
    logic [15:0] marker_count;
  } in_item_t;

  typedef struct packed {
    logic        cluster_valid;
    logic [6:0]  cluster_x;
    logic [6:0]  cluster_y;
    logic [23:0] cluster_count;
    logic        last;
  } out_item_t;

  // One pixel moving down the cell chain.
  typedef struct packed {
    logic              valid;
    logic [CW-1:0]     x;
    logic [CW-1:0]     y;
    logic [AW_MAX-1:0] addr;
    logic [PW-1:0]     pix;
    logic [PW-1:0]     lft;
    logic              close;
    logic [DW-1:0]     bestd;
    logic [KW-1:0]     bestk;
  } query_t;

  // Broadcast controls shared by every cell.
  typedef struct packed {
    logic [TW-1:0] total;
    logic [DW-1:0] limit;
    logic          load_en;
    logic [KW-1:0] load_idx;
    logic [CW-1:0] load_x;
    logic [CW-1:0] load_y;
    logic [SW-1:0] load_cnt;
    logic          add_en;
    logic [KW-1:0] add_idx;
    logic [PW-1:0] add_val;
    logic          shift_en;
  } cell_ctl_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [SW-1:0] cnt;
  } centre_t;

  function automatic logic [PW-1:0] sat_pix(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PW] ? {PW{1'b1}} : s[PW-1:0];
  endfunction

  function automatic logic [SW-1:0] sat_cnt(input logic [SW-1:0] a, input logic [PW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + (SW+1)'(b);
    return s[SW] ? {SW{1'b1}} : s[SW-1:0];
  endfunction

endpackage

@@ rtl/ggpc_ram.sv @@
module ggpc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ggpc_cell.sv @@
module ggpc_cell #(
  parameter int K = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ggpc_pkg::cell_ctl_t ctl,
  input  ggpc_pkg::query_t    q_in,
  output ggpc_pkg::query_t    q_out,
  input  ggpc_pkg::centre_t   nbr,
  output ggpc_pkg::centre_t   cur
);
  import ggpc_pkg::*;

  centre_t         c_r;
  query_t          q_r;
  query_t          q_nxt;
  logic            active;
  logic [CW-1:0]   dx;
  logic [CW-1:0]   dy;
  logic [2*CW-1:0] dx2;
  logic [2*CW-1:0] dy2;
  logic [DW-1:0]   d;
  logic            take;

  always_comb begin
    active = ctl.total > TW'(K);
    dx     = (q_in.x > c_r.x) ? q_in.x - c_r.x : c_r.x - q_in.x;
    dy     = (q_in.y > c_r.y) ? q_in.y - c_r.y : c_r.y - q_in.y;
    dx2    = dx * dx;
    dy2    = dy * dy;
    d      = DW'(dx2) + DW'(dy2);
    take   = active && ((K == 0) || (d < q_in.bestd));
    q_nxt       = q_in;
    q_nxt.close = q_in.close | (active && (d < ctl.limit));
    if (take) begin
      q_nxt.bestd = d;
      q_nxt.bestk = KW'(K);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  // Cluster contents shift toward cell zero while results are sent.
  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      c_r <= nbr;
    end else if (ctl.load_en && ctl.load_idx == KW'(K)) begin
      c_r.x   <= ctl.load_x;
      c_r.y   <= ctl.load_y;
      c_r.cnt <= ctl.load_cnt;
    end else if (ctl.add_en && ctl.add_idx == KW'(K)) begin
      c_r.cnt <= sat_cnt(c_r.cnt, ctl.add_val);
    end
  end

  assign q_out = q_r;
  assign cur   = c_r;

endmodule

@@ rtl/greedy_grid_point_clustering.sv @@
// Channel  Ports                          Handshake
// input    start, busy, in_item           taken when start && !busy
// result   out_valid, out_item            one-cycle strobe, cannot be held off
// config   cfg_we, cfg_index, cfg_wdata   written when cfg_we
//
// Add items go back to back, even at one pixel.
// A run makes one scan of the used area per cluster plus a closing empty scan (none when
// the table fills), a clamped (2R+1)^2 box sweep per cluster, a spill scan when the table
// fills and one leftover scan when any cluster was found; each phase ends with a drain of
// the cell chain. Then the results go out back to back, and a clearing pass over the whole
// grid follows, which also runs after reset; busy stays high throughout.
module greedy_grid_point_clustering #(
  parameter int GRID_W       = 128,
  parameter int GRID_H       = 128,
  parameter int MAX_CLUSTERS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ggpc_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ggpc_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);
  import ggpc_pkg::*;

  localparam int NPIX  = GRID_W * GRID_H;
  localparam int MAW   = $clog2(NPIX);
  localparam int DRAIN = MAX_CLUSTERS + 2;
  localparam int DRW   = $clog2(DRAIN + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PASS, S_BOX, S_SPILL, S_LEFT, S_EMIT
  } state_t;

  state_t state_r;

  logic [5:0] radius_r;
  logic [7:0] gwidth_r;
  logic [7:0] gheight_r;

  logic [MAW-1:0] clr_r;
  logic [CW-1:0]  sx_r, sy_r, xlo_r, xhi_r, yhi_r;
  logic           scan_on_r;
  logic [DRW-1:0] drain_r;
  logic           tag_valid_r;
  logic [CW-1:0]  tag_x_r, tag_y_r;
  logic [MAW-1:0] tag_addr_r;
  logic           s1_valid_r;
  logic [MAW-1:0] s1_addr_r;
  logic [15:0]    s1_cnt_r;
  logic           wb_valid_r;
  logic [MAW-1:0] wb_addr_r;
  logic [PW-1:0]  wb_data_r;
  logic [PW-1:0]  best_r;
  logic [CW-1:0]  bx_r, by_r;
  logic [SW-1:0]  sum_r;
  logic [TW-1:0]  total_r;
  logic [TW-1:0]  remain_r;

  logic [DIMW-1:0] weff, heff;
  logic [CW-1:0]   wm1, hm1;
  logic            accept, add_ok;
  logic [MAW-1:0]  add_addr, scan_addr, raddr;
  logic            scan_last, phase_done;
  logic [PW-1:0]   pix_rdata, lft_rdata, add_base;
  logic            pix_we, lft_we;
  logic [MAW-1:0]  pix_waddr, lft_waddr;
  logic [PW-1:0]   pix_wdata, lft_wdata;
  logic [6:0]      r2;
  logic [CW-1:0]   rr;
  logic [DIMW-1:0] bxr, byr;
  cell_ctl_t       ctl;
  query_t          q_chain [MAX_CLUSTERS+1];
  centre_t         cen [MAX_CLUSTERS+1];
  query_t          q_end;

  always_comb begin
    weff      = (DIMW'(gwidth_r) > DIMW'(GRID_W)) ? DIMW'(GRID_W) : DIMW'(gwidth_r);
    heff      = (DIMW'(gheight_r) > DIMW'(GRID_H)) ? DIMW'(GRID_H) : DIMW'(gheight_r);
    wm1       = CW'(weff - DIMW'(1));
    hm1       = CW'(heff - DIMW'(1));
    accept    = start && !busy;
    add_ok    = (DIMW'(in_item.pixel_x) < weff) && (DIMW'(in_item.pixel_y) < heff);
    add_addr  = MAW'(int'(in_item.pixel_y) * GRID_W + int'(in_item.pixel_x));
    scan_addr = MAW'(int'(sy_r) * GRID_W + int'(sx_r));
    raddr     = (state_r == S_IDLE) ? add_addr : scan_addr;
    scan_last = (sx_r == xhi_r) && (sy_r == yhi_r);
    phase_done = !scan_on_r && (drain_r == '0);
    add_base  = (wb_valid_r && wb_addr_r == s1_addr_r) ? wb_data_r : pix_rdata;
    r2        = {radius_r, 1'b0};
    rr        = CW'(radius_r);
    bxr       = DIMW'(bx_r) + DIMW'(rr);
    byr       = DIMW'(by_r) + DIMW'(rr);
    q_end     = q_chain[MAX_CLUSTERS];
  end

  // Memory write ports: pending add first, then the phase in progress.
  always_comb begin
    pix_we    = 1'b0;
    pix_waddr = tag_addr_r;
    pix_wdata = '0;
    lft_we    = 1'b0;
    lft_waddr = tag_addr_r;
    lft_wdata = '0;
    if (s1_valid_r) begin
      pix_we    = 1'b1;
      pix_waddr = s1_addr_r;
      pix_wdata = sat_pix(add_base, PW'(s1_cnt_r));
    end else begin
      case (state_r)
        S_CLEAR: begin
          pix_we    = 1'b1;
          pix_waddr = clr_r;
          lft_we    = 1'b1;
          lft_waddr = clr_r;
        end
        S_PASS: begin
          if (q_end.valid && q_end.pix > best_r && q_end.close) begin
            pix_we    = 1'b1;
            pix_waddr = q_end.addr[MAW-1:0];
            lft_we    = 1'b1;
            lft_waddr = q_end.addr[MAW-1:0];
            lft_wdata = sat_pix(q_end.lft, q_end.pix);
          end
        end
        S_BOX: begin
          pix_we = tag_valid_r;
        end
        S_SPILL: begin
          pix_we    = tag_valid_r;
          lft_we    = tag_valid_r;
          lft_wdata = sat_pix(lft_rdata, pix_rdata);
        end
        default: begin
        end
      endcase
    end
  end

  ggpc_ram #(.WIDTH(PW), .DEPTH(NPIX)) u_pix_ram (
    .clk(clk), .we(pix_we), .waddr(pix_waddr), .wdata(pix_wdata),
    .raddr(raddr), .rdata(pix_rdata)
  );

  ggpc_ram #(.WIDTH(PW), .DEPTH(NPIX)) u_lft_ram (
    .clk(clk), .we(lft_we), .waddr(lft_waddr), .wdata(lft_wdata),
    .raddr(raddr), .rdata(lft_rdata)
  );

  always_comb begin
    ctl.total    = total_r;
    ctl.limit    = DW'(r2) * DW'(r2);
    ctl.load_en  = (state_r == S_BOX) && phase_done;
    ctl.load_idx = KW'(total_r);
    ctl.load_x   = bx_r;
    ctl.load_y   = by_r;
    ctl.load_cnt = sum_r;
    ctl.add_en   = (state_r == S_LEFT) && q_end.valid && (q_end.lft != '0);
    ctl.add_idx  = q_end.bestk;
    ctl.add_val  = q_end.lft;
    ctl.shift_en = (state_r == S_EMIT) && (total_r != '0);

    q_chain[0].valid = tag_valid_r && ((state_r == S_PASS) || (state_r == S_LEFT));
    q_chain[0].x     = tag_x_r;
    q_chain[0].y     = tag_y_r;
    q_chain[0].addr  = AW_MAX'(tag_addr_r);
    q_chain[0].pix   = pix_rdata;
    q_chain[0].lft   = lft_rdata;
    q_chain[0].close = 1'b0;
    q_chain[0].bestd = '0;
    q_chain[0].bestk = '0;
    cen[MAX_CLUSTERS] = '0;
  end

  for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
    ggpc_cell #(.K(k)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .q_in(q_chain[k]), .q_out(q_chain[k+1]),
      .nbr(cen[k+1]), .cur(cen[k])
    );
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      radius_r    <= 6'd8;
      gwidth_r    <= 8'd128;
      gheight_r   <= 8'd128;
      scan_on_r   <= 1'b0;
      drain_r     <= '0;
      tag_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      wb_valid_r  <= 1'b0;
      total_r     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RADIUS: radius_r  <= cfg_wdata[5:0];
          CFG_WIDTH:  gwidth_r  <= cfg_wdata;
          CFG_HEIGHT: gheight_r <= cfg_wdata;
          default: begin
          end
        endcase
      end

      // Add pipeline with forwarding of the previous write.
      s1_valid_r <= accept && (in_item.operation == OP_ADD) && add_ok;
      s1_addr_r  <= add_addr;
      s1_cnt_r   <= in_item.marker_count;
      wb_valid_r <= s1_valid_r;
      wb_addr_r  <= s1_addr_r;
      wb_data_r  <= pix_wdata;

      // Area scanner: one address per cycle, then a drain of the cell chain.
      tag_valid_r <= scan_on_r;
      tag_x_r     <= sx_r;
      tag_y_r     <= sy_r;
      tag_addr_r  <= scan_addr;
      if (scan_on_r) begin
        if (scan_last) begin
          scan_on_r <= 1'b0;
          drain_r   <= DRW'(DRAIN);
        end else if (sx_r == xhi_r) begin
          sx_r <= xlo_r;
          sy_r <= sy_r + CW'(1);
        end else begin
          sx_r <= sx_r + CW'(1);
        end
      end else if (drain_r != '0) begin
        drain_r <= drain_r - DRW'(1);
      end

      out_valid <= (state_r == S_EMIT);

      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + MAW'(1);
          if (clr_r == MAW'(NPIX - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          clr_r <= '0;
          if (accept && in_item.operation == OP_RUN) begin
            total_r <= '0;
            best_r  <= '0;
            if (weff == '0 || heff == '0) begin
              state_r <= S_EMIT;
            end else begin
              state_r   <= S_PASS;
              scan_on_r <= 1'b1;
              sx_r      <= '0;
              sy_r      <= '0;
              xlo_r     <= '0;
              xhi_r     <= wm1;
              yhi_r     <= hm1;
            end
          end
        end
        S_PASS: begin
          if (q_end.valid && q_end.pix > best_r && !q_end.close) begin
            best_r <= q_end.pix;
            bx_r   <= q_end.x;
            by_r   <= q_end.y;
          end
          if (phase_done) begin
            if (best_r == '0) begin
              sx_r    <= '0;
              sy_r    <= '0;
              xlo_r   <= '0;
              xhi_r   <= wm1;
              yhi_r   <= hm1;
              // Without a cluster there is nothing for leftovers to join.
              scan_on_r <= (total_r != '0);
              state_r   <= (total_r != '0) ? S_LEFT : S_EMIT;
            end else begin
              scan_on_r <= 1'b1;
              state_r <= S_BOX;
              sum_r   <= '0;
              sx_r    <= (bx_r > rr) ? bx_r - rr : '0;
              xlo_r   <= (bx_r > rr) ? bx_r - rr : '0;
              sy_r    <= (by_r > rr) ? by_r - rr : '0;
              xhi_r   <= (bxr < DIMW'(wm1)) ? CW'(bxr) : wm1;
              yhi_r   <= (byr < DIMW'(hm1)) ? CW'(byr) : hm1;
            end
          end
        end
        S_BOX: begin
          if (tag_valid_r) begin
            sum_r <= sat_cnt(sum_r, pix_rdata);
          end
          if (phase_done) begin
            total_r   <= total_r + TW'(1);
            best_r    <= '0;
            scan_on_r <= 1'b1;
            sx_r      <= '0;
            sy_r      <= '0;
            xlo_r     <= '0;
            xhi_r     <= wm1;
            yhi_r     <= hm1;
            state_r   <= (total_r + TW'(1) == TW'(MAX_CLUSTERS)) ? S_SPILL : S_PASS;
          end
        end
        S_SPILL: begin
          if (phase_done) begin
            scan_on_r <= 1'b1;
            sx_r      <= '0;
            sy_r      <= '0;
            state_r   <= S_LEFT;
          end
        end
        S_LEFT: begin
          if (phase_done) begin
            remain_r <= total_r;
            state_r  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (total_r == '0) begin
            out_item <= '{cluster_valid: 1'b0, cluster_x: '0, cluster_y: '0,
                          cluster_count: '0, last: 1'b1};
            state_r <= S_CLEAR;
          end else begin
            out_item.cluster_valid <= 1'b1;
            out_item.cluster_x     <= cen[0].x[6:0];
            out_item.cluster_y     <= cen[0].y[6:0];
            out_item.cluster_count <= cen[0].cnt;
            out_item.last          <= (remain_r == TW'(1));
            remain_r               <= remain_r - TW'(1);
            if (remain_r == TW'(1)) begin
              state_r <= S_CLEAR;
            end
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

@@ tb/greedy_grid_point_clustering_test.sv @@
`timescale 1ns / 1ps

module greedy_grid_point_clustering_test;
  import ggpc_pkg::*;

  localparam int GRID_W       = 128;
  localparam int GRID_H       = 128;
  localparam int MAX_CLUSTERS = 64;
  localparam int PIX_CAP      = 20'hFFFFF;
  localparam int CNT_CAP      = 24'hFFFFFF;
  localparam int CYCLE_LIMIT  = 6000000;
  localparam int TARGET_ITEMS = 460;

  class cluster_scoreboard;
    int unsigned radius, width, height;
    int unsigned pix_grid[GRID_W*GRID_H];
    int unsigned spill_grid[GRID_W*GRID_H];
    int unsigned cen_x[MAX_CLUSTERS], cen_y[MAX_CLUSTERS], cen_cnt[MAX_CLUSTERS];
    int unsigned n_clusters;
    out_item_t   clusters_due[$];
    int unsigned mismatches;

    function new();
      radius = 8;
      width = 128;
      height = 128;
      n_clusters = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] v);
      case (idx)
        CFG_RADIUS: radius = v[5:0];
        CFG_WIDTH:  width  = v;
        CFG_HEIGHT: height = v;
        default: ;
      endcase
    endfunction

    function int unsigned sat(int unsigned a, int unsigned b, int unsigned cap);
      longint unsigned s;
      s = longint'(a) + longint'(b);
      return (s > cap) ? cap : int'(s);
    endfunction

    function int unsigned sq_dist(int unsigned ax, int unsigned ay, int unsigned bx,
                                  int unsigned by);
      int unsigned dx, dy;
      dx = ax > bx ? ax - bx : bx - ax;
      dy = ay > by ? ay - by : by - ay;
      return dx * dx + dy * dy;
    endfunction

    function bit near_cluster(int unsigned x, int unsigned y, int unsigned lim);
      for (int unsigned k = 0; k < n_clusters; k++)
        if (sq_dist(cen_x[k], cen_y[k], x, y) < lim) return 1;
      return 0;
    endfunction

    function void cluster_grid(int unsigned w, int unsigned h);
      int unsigned r, lim, best, bx, by, x0, x1, y0, y1, i, d, bd, bk;
      r = radius;
      lim = 4 * r * r;
      n_clusters = 0;
      while (n_clusters < MAX_CLUSTERS) begin
        best = 0;
        bx = 0;
        by = 0;
        for (int unsigned y = 0; y < h; y++)
          for (int unsigned x = 0; x < w; x++) begin
            i = y * GRID_W + x;
            if (pix_grid[i] > best) begin
              if (near_cluster(x, y, lim)) begin
                spill_grid[i] = sat(spill_grid[i], pix_grid[i], PIX_CAP);
                pix_grid[i] = 0;
              end else begin
                best = pix_grid[i];
                bx = x;
                by = y;
              end
            end
          end
        if (best == 0) break;
        cen_x[n_clusters] = bx;
        cen_y[n_clusters] = by;
        pix_grid[by * GRID_W + bx] = 0;
        x0 = bx > r ? bx - r : 0;
        y0 = by > r ? by - r : 0;
        x1 = bx + r < w - 1 ? bx + r : w - 1;
        y1 = by + r < h - 1 ? by + r : h - 1;
        for (int unsigned y = y0; y <= y1; y++)
          for (int unsigned x = x0; x <= x1; x++) begin
            i = y * GRID_W + x;
            best = sat(best, pix_grid[i], CNT_CAP);
            pix_grid[i] = 0;
          end
        cen_cnt[n_clusters] = best;
        n_clusters++;
      end
      // Once the cluster table is full, whatever is left is folded in as leftovers.
      if (n_clusters >= MAX_CLUSTERS)
        for (int unsigned y = 0; y < h; y++)
          for (int unsigned x = 0; x < w; x++) begin
            i = y * GRID_W + x;
            spill_grid[i] = sat(spill_grid[i], pix_grid[i], PIX_CAP);
            pix_grid[i] = 0;
          end
      if (n_clusters > 0)
        for (int unsigned y = 0; y < h; y++)
          for (int unsigned x = 0; x < w; x++) begin
            i = y * GRID_W + x;
            if (spill_grid[i] != 0) begin
              bd = 0;
              bk = 0;
              for (int unsigned k = 0; k < n_clusters; k++) begin
                d = sq_dist(cen_x[k], cen_y[k], x, y);
                if (k == 0 || d < bd) begin
                  bd = d;
                  bk = k;
                end
              end
              cen_cnt[bk] = sat(cen_cnt[bk], spill_grid[i], CNT_CAP);
            end
          end
      foreach (pix_grid[j]) begin
        pix_grid[j] = 0;
        spill_grid[j] = 0;
      end
    endfunction

    function void note_input(in_item_t it);
      int unsigned w, h, i;
      out_item_t e;
      w = width > GRID_W ? GRID_W : width;
      h = height > GRID_H ? GRID_H : height;
      if (it.operation == OP_ADD) begin
        if (it.pixel_x < w && it.pixel_y < h) begin
          i = it.pixel_y * GRID_W + it.pixel_x;
          pix_grid[i] = sat(pix_grid[i], it.marker_count, PIX_CAP);
        end
        return;
      end
      cluster_grid(w, h);
      if (n_clusters == 0) begin
        e = '0;
        e.last = 1'b1;
        clusters_due.push_back(e);
      end
      for (int unsigned k = 0; k < n_clusters; k++) begin
        e.cluster_valid = 1'b1;
        e.cluster_x     = cen_x[k][6:0];
        e.cluster_y     = cen_y[k][6:0];
        e.cluster_count = cen_cnt[k][23:0];
        e.last          = (k + 1 == n_clusters);
        clusters_due.push_back(e);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      bit ok;
      if (clusters_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected cluster result: valid=%0d x=%0d y=%0d count=%0d last=%0d",
                   got.cluster_valid, got.cluster_x, got.cluster_y, got.cluster_count,
                   got.last);
        return;
      end
      e = clusters_due.pop_front();
      ok = (got.cluster_valid === e.cluster_valid) && (got.cluster_x === e.cluster_x) &&
           (got.cluster_y === e.cluster_y) && (got.cluster_count === e.cluster_count) &&
           (got.last === e.last);
      if (!ok) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"cluster mismatch: expected valid=%0d x=%0d y=%0d count=%0d last=%0d,",
                    " got valid=%0d x=%0d y=%0d count=%0d last=%0d"},
                   e.cluster_valid, e.cluster_x, e.cluster_y, e.cluster_count, e.last,
                   got.cluster_valid, got.cluster_x, got.cluster_y, got.cluster_count,
                   got.last);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_item;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  cluster_scoreboard sb;
  int unsigned items_sent;
  int unsigned cycles;
  bit          no_gaps;

  greedy_grid_point_clustering #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H),
    .MAX_CLUSTERS(MAX_CLUSTERS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[greedy_grid_point_clustering] ERROR");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid) sb.check_result(out_item);

  task automatic idle_gap();
    int unsigned p, n;
    p = $urandom_range(0, 99);
    n = p < 60 ? 0 : (p < 92 ? $urandom_range(1, 3) : $urandom_range(8, 40));
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance, or later after an idle gap.
  task automatic send_item(in_item_t it);
    start <= 1'b1;
    in_item <= it;
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_input(it);
    items_sent++;
    @(negedge clk);
    if (!no_gaps) idle_gap();
  endtask

  task automatic add_px(int unsigned x, int unsigned y, int unsigned c);
    in_item_t it;
    it.operation = OP_ADD;
    it.pixel_x = x[6:0];
    it.pixel_y = y[6:0];
    it.marker_count = c[15:0];
    send_item(it);
  endtask

  task automatic run_grid();
    in_item_t it;
    it = in_item_t'($urandom);
    it.operation = OP_RUN;
    send_item(it);
  endtask

  // Waits out the last results and the clearing pass before any register write.
  task automatic settle();
    start <= 1'b0;
    while (sb.clusters_due.size() != 0) @(negedge clk);
    repeat (GRID_W * GRID_H + 4 * MAX_CLUSTERS) @(negedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [1:0] idx, logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic set_shape(int unsigned r, int unsigned w, int unsigned h);
    write_reg(CFG_RADIUS, r[7:0]);
    write_reg(CFG_WIDTH, w[7:0]);
    write_reg(CFG_HEIGHT, h[7:0]);
    cfg_we <= 1'b0;
  endtask

  function automatic int unsigned rand_count();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return $urandom_range(1, 50);
    if (p < 60) return 65535;
    if (p < 70) return 0;
    return $urandom_range(0, 65535);
  endfunction

  function automatic int unsigned rand_dim();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 85) return $urandom_range(1, 16);
    if (p < 95) return $urandom_range(17, 40);
    return $urandom_range(128, 255);
  endfunction

  task automatic random_phase();
    int unsigned r, w, h, wx, hy, n, runs, p;
    p = $urandom_range(0, 99);
    r = p < 70 ? $urandom_range(0, 4) : (p < 95 ? $urandom_range(0, 32) : 63);
    w = rand_dim();
    h = rand_dim();
    set_shape(r, w, h);
    wx = w > GRID_W ? GRID_W : w;
    hy = h > GRID_H ? GRID_H : h;
    no_gaps = ($urandom_range(0, 3) == 0);
    runs = $urandom_range(1, 2);
    repeat (runs) begin
      n = (wx * hy > 1024) ? $urandom_range(1, 6) : $urandom_range(3, 25);
      repeat (n)
        if ($urandom_range(0, 99) < 85)
          add_px($urandom_range(0, wx - 1), $urandom_range(0, hy - 1), rand_count());
        else
          add_px($urandom_range(0, 127), $urandom_range(0, 127), rand_count());
      run_grid();
    end
    no_gaps = 0;
    settle();
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    cycles = 0;
    no_gaps = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_RADIUS;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset shape: an empty run first, then corners, a zero count and a near pixel.
    run_grid();
    add_px(0, 0, 1);
    add_px(127, 127, 65535);
    add_px(127, 127, 65535);
    add_px(5, 0, 0);
    add_px(3, 0, 40);
    add_px(20, 20, 500);
    run_grid();
    settle();

    // Zero radius with seventy adds landing on only sixteen distinct pixels.
    set_shape(0, 16, 16);
    for (int unsigned j = 0; j < 70; j++) add_px(j % 16, (j * 7) % 16, $urandom_range(1, 300));
    run_grid();
    settle();

    // A pixel too close to the first cluster lands midway between two clusters.
    set_shape(2, 8, 8);
    add_px(0, 0, 100);
    add_px(6, 0, 100);
    add_px(3, 0, 50);
    run_grid();
    settle();

    // Pixel and cluster saturation inside one box covering the whole grid.
    set_shape(63, 8, 8);
    no_gaps = 1;
    for (int unsigned j = 0; j < 17; j++)
      repeat (16) add_px(j % 8, j / 8, 65535);
    repeat (17) add_px(7, 7, 65535);
    no_gaps = 0;
    run_grid();
    settle();

    // Counts left outside a shrunken size are thrown away.
    set_shape(32, 255, 3);
    add_px(100, 2, 77);
    add_px(1, 1, 9);
    add_px(3, 0, 12);
    settle();
    set_shape(1, 4, 2);
    run_grid();
    settle();

    // Zero width ignores every add.
    set_shape(5, 0, 5);
    add_px(0, 0, 10);
    add_px(2, 3, 11);
    run_grid();
    settle();

    while (items_sent < TARGET_ITEMS) random_phase();

    start <= 1'b0;
    while (sb.clusters_due.size() != 0) @(negedge clk);
    repeat (GRID_W * GRID_H + 4 * MAX_CLUSTERS) @(negedge clk);
    if (sb.mismatches == 0 && sb.clusters_due.size() == 0) begin
      $display("[greedy_grid_point_clustering] OK");
    end else begin
      $display("[greedy_grid_point_clustering] ERROR");
    end
    $finish;
  end

endmodule
